[hw/rtl/pmid_pkg.sv]
// Package: shared constants, register codes, beat types and helpers for the image distance core
`timescale 1ns / 1ps

package pmid_pkg;

    localparam int DATA_W        = 32;
    localparam int AXES_MAX      = 3;
    localparam int DEF_AXES      = 3;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DIV_STEPS     = DATA_W;
    localparam int SQRT_STEPS    = DATA_W;
    // divider cells, wrap, square, two adds, root cells
    localparam int LATENCY       = DIV_STEPS + SQRT_STEPS + 4;

    typedef enum logic [1:0] {
        REG_BOX_X  = 2'd0,
        REG_BOX_Y  = 2'd1,
        REG_BOX_Z  = 2'd2,
        REG_PERIOD = 2'd3
    } cfg_reg_t;

    // one beat of the remainder chain
    typedef struct packed {
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] num;
    } div_beat_t;

    // one beat of the square-root chain, with the wrapped values riding along
    typedef struct packed {
        logic [2*DATA_W-1:0]                rad;
        logic [DATA_W+1:0]                  rem;
        logic [DATA_W-1:0]                  root;
        logic [AXES_MAX-1:0][DATA_W-1:0]    wrapped;
    } sqrt_beat_t;

    function automatic logic [DATA_W-1:0] abs_val(logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

endpackage

[hw/rtl/pmid_div_cell.sv]
// Module: one restoring remainder step, one dividend bit per cell
`timescale 1ns / 1ps

module pmid_div_cell (
    input  logic                     clk,
    input  logic [31:0]              box,
    input  pmid_pkg::div_beat_t      beat_in,
    output pmid_pkg::div_beat_t      beat_out
);

    logic [32:0]         trial;
    logic [32:0]         diff;
    logic                fits;
    pmid_pkg::div_beat_t beat_reg;
    pmid_pkg::div_beat_t beat_next;

    // shift in the next dividend bit and subtract the box where it fits
    always_comb
    begin
        trial            = {beat_in.rem, beat_in.num[31]};
        diff             = trial - {1'b0, box};
        fits             = trial >= {1'b0, box};
        beat_next.d      = beat_in.d;
        beat_next.rem    = fits ? diff[31:0] : trial[31:0];
        beat_next.num    = {beat_in.num[30:0], 1'b0};
    end

    // hand the beat on
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

[hw/rtl/pmid_sqrt_cell.sv]
// Module: one digit of the integer square root, two radicand bits per cell
`timescale 1ns / 1ps

module pmid_sqrt_cell (
    input  logic                     clk,
    input  pmid_pkg::sqrt_beat_t     beat_in,
    output pmid_pkg::sqrt_beat_t     beat_out
);

    logic [35:0]          part;
    logic [35:0]          trial;
    logic [35:0]          diff;
    logic                 fits;
    pmid_pkg::sqrt_beat_t beat_reg;
    pmid_pkg::sqrt_beat_t beat_next;

    // bring down two bits and try the next root digit
    always_comb
    begin
        part              = {beat_in.rem, beat_in.rad[63:62]};
        trial             = {2'b00, beat_in.root, 2'b01};
        diff              = part - trial;
        fits              = part >= trial;
        beat_next.rad     = {beat_in.rad[61:0], 2'b00};
        beat_next.rem     = fits ? diff[33:0] : part[33:0];
        beat_next.root    = {beat_in.root[30:0], fits};
        beat_next.wrapped = beat_in.wrapped;
    end

    // hand the beat on
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

[hw/rtl/periodic_minimum_image_distance_core.sv]
// Module: top level of the periodic minimum-image distance core
`timescale 1ns / 1ps

// Takes one difference vector per clock while busy is low and returns its
// minimum-image wrap and Euclidean length; each accepted start beat shows
// as a one-cycle done strobe at the end of the pipeline. The pipeline is a
// 32-cell remainder chain per axis (one dividend bit per cell), a wrap
// stage, a square stage, two add stages and a 32-cell square-root chain
// (two radicand bits per cell). busy is high only in reset and the cycle
// after it; cfg_ready is the inverse of busy. The receiver cannot stall
// done, so results must be taken as they come. Write configuration only with
// no item in flight.

module periodic_minimum_image_distance_core #(
    parameter int AXES      = pmid_pkg::DEF_AXES,
    parameter int FRAC_BITS = pmid_pkg::DEF_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] diff_x,
    input  logic [31:0] diff_y,
    input  logic [31:0] diff_z,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [31:0] wrapped_x,
    output logic [31:0] wrapped_y,
    output logic [31:0] wrapped_z,
    output logic [31:0] distance
);

    localparam int NA   = pmid_pkg::AXES_MAX;
    localparam int LAT  = pmid_pkg::LATENCY;
    localparam int DSTP = pmid_pkg::DIV_STEPS;
    localparam int SSTP = pmid_pkg::SQRT_STEPS;

    logic [31:0]              box_reg [0:NA-1];
    logic [2:0]               mask_reg;
    logic                     busy_reg;
    logic [LAT-1:0]           vld_reg;
    logic [31:0]              diff_in [0:NA-1];
    logic [NA-1:0][31:0]      wrap_next;
    logic [NA-1:0][31:0]      wrap_reg;
    logic [NA-1:0][31:0]      wrap2_reg;
    logic [NA-1:0][31:0]      wrap3_reg;
    logic [NA-1:0][31:0]      wrap4_reg;
    logic [63:0]              sq_reg [0:NA-1];
    logic [63:0]              sum1_reg;
    logic [63:0]              sq2_reg;
    logic [63:0]              sum2_reg;
    pmid_pkg::sqrt_beat_t     root_chain [0:SSTP];

    assign diff_in[0] = diff_x;
    assign diff_in[1] = diff_y;
    assign diff_in[2] = diff_z;

    // configuration registers, ready once out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg[0] <= 32'(1) << FRAC_BITS;
            box_reg[1] <= 32'(1) << FRAC_BITS;
            box_reg[2] <= 32'(1) << FRAC_BITS;
            mask_reg   <= 3'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pmid_pkg::cfg_reg_t'(cfg_index))
                pmid_pkg::REG_BOX_X:  box_reg[0] <= cfg_data;
                pmid_pkg::REG_BOX_Y:  box_reg[1] <= cfg_data;
                pmid_pkg::REG_BOX_Z:  box_reg[2] <= cfg_data;
                pmid_pkg::REG_PERIOD: mask_reg   <= cfg_data[2:0];
                default:              mask_reg   <= mask_reg;
            endcase
        end
    end

    assign cfg_ready = ~busy_reg;

    // hold busy through reset, then drop it; advance the valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            vld_reg  <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg  <= {vld_reg[LAT-2:0], start & ~busy_reg};
        end
    end

    assign busy = busy_reg;
    assign done = vld_reg[LAT-1];

    // per axis: remainder chain, then the wrap decision
    for (genvar g = 0; g < NA; g++)
    begin : g_axis
        if (g < AXES)
        begin : g_on
            pmid_pkg::div_beat_t chain [0:DSTP];
            logic                neg;
            logic                half;
            logic                per;
            logic signed [33:0]  v;
            logic signed [33:0]  s;
            logic [31:0]         res;
            logic [31:0]         pick;

            assign chain[0].d   = diff_in[g];
            assign chain[0].rem = '0;
            assign chain[0].num = pmid_pkg::abs_val(diff_in[g]);

            for (genvar c = 0; c < DSTP; c++)
            begin : g_cell
                pmid_div_cell u_cell (
                    .clk      (clk),
                    .box      (box_reg[g]),
                    .beat_in  (chain[c]),
                    .beat_out (chain[c+1])
                );
            end

            // remainder at or above half the box rounds one more box away
            always_comb
            begin
                neg  = chain[DSTP].d[31];
                half = {chain[DSTP].rem, 1'b0} >= {1'b0, box_reg[g]};
                per  = mask_reg[g] && (box_reg[g] != 32'd0);
                v    = half ? ($signed({2'b00, chain[DSTP].rem})
                               - $signed({2'b00, box_reg[g]}))
                            : $signed({2'b00, chain[DSTP].rem});
                s    = neg ? -v : v;
                if (s > $signed(34'sh0_7FFF_FFFF))
                    res = 32'h7FFF_FFFF;
                else if (s < -$signed(34'sh0_8000_0000))
                    res = 32'h8000_0000;
                else
                    res = s[31:0];
                pick = per ? res : chain[DSTP].d;
            end

            assign wrap_next[g] = pick;
        end
        else
        begin : g_off
            assign wrap_next[g] = '0;
        end
    end

    // wrap, square, and sum stages
    always_ff @(posedge clk)
    begin
        wrap_reg  <= wrap_next;
        wrap2_reg <= wrap_reg;
        wrap3_reg <= wrap2_reg;
        wrap4_reg <= wrap3_reg;
        for (int i = 0; i < NA; i++)
        begin
            sq_reg[i] <= {32'd0, pmid_pkg::abs_val(wrap_reg[i])}
                       * {32'd0, pmid_pkg::abs_val(wrap_reg[i])};
        end
        sum1_reg <= sq_reg[0] + sq_reg[1];
        sq2_reg  <= sq_reg[2];
        sum2_reg <= sum1_reg + sq2_reg;
    end

    // square-root chain
    assign root_chain[0].rad     = sum2_reg;
    assign root_chain[0].rem     = '0;
    assign root_chain[0].root    = '0;
    assign root_chain[0].wrapped = wrap4_reg;

    for (genvar c = 0; c < SSTP; c++)
    begin : g_root
        pmid_sqrt_cell u_cell (
            .clk      (clk),
            .beat_in  (root_chain[c]),
            .beat_out (root_chain[c+1])
        );
    end

    assign wrapped_x = root_chain[SSTP].wrapped[0];
    assign wrapped_y = root_chain[SSTP].wrapped[1];
    assign wrapped_z = root_chain[SSTP].wrapped[2];
    assign distance  = root_chain[SSTP].root;

endmodule

[hw/rtl/pmid_checker.sv]
// Module: port-level checker for the image distance core, bound to the top level
`timescale 1ns / 1ps

module pmid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        done,
    input logic [31:0] wrapped_x,
    input logic [31:0] wrapped_y,
    input logic [31:0] wrapped_z,
    input logic [31:0] distance
);

    localparam int LAT = pmid_pkg::LATENCY;

    // every accepted beat comes back after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat gave no result");

    // no result without a beat accepted the latency before
    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without accepted beat");

    // zero length exactly when all wrapped components are zero
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((distance == 32'd0) ==
                  (wrapped_x == 32'd0 && wrapped_y == 32'd0 && wrapped_z == 32'd0)))
        else $error("distance disagrees with wrapped vector");

    // length at least the magnitude of the x and y components
    a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (distance >= pmid_pkg::abs_val(wrapped_x)
               && distance >= pmid_pkg::abs_val(wrapped_y)))
        else $error("distance below component");

    // configuration never stalls once busy has dropped
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && !busy) |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind periodic_minimum_image_distance_core pmid_checker u_pmid_checker (.*);

[tb/tb_top.sv]
// Testbench: drives diffs and register writes, predicts wrapped vector and length
`timescale 1ns / 1ps

class pmid_scoreboard;
    logic [31:0] exp_wx[$];
    logic [31:0] exp_wy[$];
    logic [31:0] exp_wz[$];
    logic [31:0] exp_len[$];
    int errors;
    int checked;

    function new();
        errors = 0;
        checked = 0;
    endfunction

    // note the prediction for one accepted beat
    function void note_input(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                             logic [31:0] len);
        exp_wx.push_back(wx);
        exp_wy.push_back(wy);
        exp_wz.push_back(wz);
        exp_len.push_back(len);
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                               logic [31:0] len);
        logic [31:0] ex, ey, ez, ed;
        if (exp_wx.size() == 0)
        begin
            $display("%0t: result with nothing pending: %h %h %h %h",
                     $realtime, wx, wy, wz, len);
            errors++;
            return;
        end
        ex = exp_wx.pop_front();
        ey = exp_wy.pop_front();
        ez = exp_wz.pop_front();
        ed = exp_len.pop_front();
        checked++;
        if (wx !== ex)
        begin
            $display("%0t: wrapped_x expected %h actual %h", $realtime, ex, wx);
            errors++;
        end
        if (wy !== ey)
        begin
            $display("%0t: wrapped_y expected %h actual %h", $realtime, ey, wy);
            errors++;
        end
        if (wz !== ez)
        begin
            $display("%0t: wrapped_z expected %h actual %h", $realtime, ez, wz);
            errors++;
        end
        if (len !== ed)
        begin
            $display("%0t: distance expected %h actual %h", $realtime, ed, len);
            errors++;
        end
    endfunction

    function int pending();
        return exp_wx.size();
    endfunction
endclass

module tb_top;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] diff_x;
    logic [31:0] diff_y;
    logic [31:0] diff_z;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [31:0] wrapped_x;
    logic [31:0] wrapped_y;
    logic [31:0] wrapped_z;
    logic [31:0] distance;

    logic [31:0] box_x, box_y, box_z;
    logic [2:0]  period_mask;
    pmid_scoreboard sb;
    int          idle_pct;
    int          n_items;

    periodic_minimum_image_distance_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .diff_x(diff_x), .diff_y(diff_y), .diff_z(diff_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .wrapped_x(wrapped_x), .wrapped_y(wrapped_y),
        .wrapped_z(wrapped_z), .distance(distance)
    );

    always #1 clk = ~clk;

    // wrap one axis to its minimum image
    function automatic longint wrap_axis_image(logic [31:0] d_raw, logic [31:0] box,
                                                logic per);
        longint d, b, k, r;
        d = longint'($signed(d_raw));
        if (!per || box == 0)
            return d;
        b = longint'({32'd0, box});
        k = (2 * d) / b - d / b;
        r = d - k * b;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    function automatic logic [63:0] square_mag(longint v);
        logic [63:0] a;
        a = (v < 0) ? 64'(-v) : 64'(v);
        return a * a;
    endfunction

    // floor square root, digit by digit
    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void predict_image(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        longint wx, wy, wz;
        logic [63:0] sum, len;
        wx = wrap_axis_image(dx, box_x, period_mask[0]);
        wy = wrap_axis_image(dy, box_y, period_mask[1]);
        wz = wrap_axis_image(dz, box_z, period_mask[2]);
        sum = square_mag(wx) + square_mag(wy) + square_mag(wz);
        len = floor_root(sum);
        if (len > 64'hFFFF_FFFF)
            len = 64'hFFFF_FFFF;
        sb.note_input(wx[31:0], wy[31:0], wz[31:0], len[31:0]);
    endfunction

    // check each result beat as it appears
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(wrapped_x, wrapped_y, wrapped_z, distance);
    end

    task automatic write_reg(pmid_pkg::cfg_reg_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            pmid_pkg::REG_BOX_X:  box_x = val;
            pmid_pkg::REG_BOX_Y:  box_y = val;
            pmid_pkg::REG_BOX_Z:  box_z = val;
            pmid_pkg::REG_PERIOD: period_mask = val[2:0];
            default:              period_mask = period_mask;
        endcase
        @(posedge clk);
    endtask

    // drain pending results, then let the pipe empty
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (pmid_pkg::LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_boxes(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                             logic [2:0] m);
        drain();
        write_reg(pmid_pkg::REG_BOX_X, bx);
        write_reg(pmid_pkg::REG_BOX_Y, by);
        write_reg(pmid_pkg::REG_BOX_Z, bz);
        write_reg(pmid_pkg::REG_PERIOD, {29'd0, m});
    endtask

    // send one diff beat; start stays high across back-to-back beats
    task automatic send_diff(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        diff_x <= dx;
        diff_y <= dy;
        diff_z <= dz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_image(dx, dy, dz);
        n_items++;
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_diff(logic [31:0] box);
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return 32'($signed($urandom_range(8, 0)) - 4) * box;
            2: return 32'($signed($urandom_range(400, 0)) - 200) * box
                      + 32'($signed($urandom_range(2, 0)) - 1);
            3: return box >> 1;
            4: return -(box >> 1);
            default: return $urandom() >> $urandom_range(31, 0);
        endcase
    endfunction

    function automatic logic [31:0] rand_box();
        case ($urandom_range(4, 0))
            0: return 32'd1 << $urandom_range(31, 0);
            1: return $urandom_range(65535, 1);
            2: return $urandom();
            3: return 32'hFFFF_FFFF - $urandom_range(3, 0);
            default: return $urandom_range(32'h00FF_FFFF, 32'h0000_8000);
        endcase
    endfunction

    initial
    begin
        #200000;
        $display("FAIL periodic_minimum_image_distance_core");
        $finish;
    end

    initial
    begin
        logic [31:0] bx, by, bz;
        clk = 0;
        rst_n = 0;
        start = 0;
        diff_x = 0;
        diff_y = 0;
        diff_z = 0;
        cfg_valid = 0;
        cfg_index = pmid_pkg::REG_BOX_X;
        cfg_data = 0;
        box_x = 32'h0001_0000;
        box_y = 32'h0001_0000;
        box_z = 32'h0001_0000;
        period_mask = 0;
        sb = new();
        idle_pct = 0;
        n_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pass-through at reset settings
        send_diff(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_diff(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_diff(0, 0, 0);
        send_diff(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_8000);
        stop_sending();

        // directed: all axes periodic, unit box, half-box edges
        set_boxes(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 3'b111);
        send_diff(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8001);
        send_diff(32'h8000_0000, 32'h7FFF_FFFF, 32'h0003_7FFF);
        send_diff(32'hFFFC_8000, 32'h0000_7FFF, 32'h0001_0000);
        stop_sending();

        // directed: zero box lengths behave as non-periodic
        set_boxes(0, 0, 32'h0000_0003, 3'b111);
        send_diff(32'h1234_5678, 32'h8000_0000, 32'h8000_0000);
        stop_sending();

        // directed: largest and smallest boxes, mixed mask
        set_boxes(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 3'b101);
        send_diff(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_diff(32'h7FFF_FFFF, 32'h8000_0001, 32'h4000_0000);
        stop_sending();
        set_boxes(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 3'b010);
        send_diff(32'h8000_0001, 32'hC000_0000, 32'h0000_0001);
        stop_sending();

        // random phases with fresh settings
        for (int ph = 0; ph < 12; ph++)
        begin
            bx = rand_box();
            by = rand_box();
            bz = rand_box();
            set_boxes(bx, by, bz, 3'($urandom_range(7, 0)));
            idle_pct = (ph == 3) ? 0 : 9;
            for (int i = 0; i < 95; i++)
                send_diff(rand_diff(bx), rand_diff(by), rand_diff(bz));
            stop_sending();
        end

        drain();
        $display("Ran %0d diff beats over 17 register settings; %0d results checked.",
                 n_items, sb.checked);
        if (sb.errors == 0)
            $display("PASS periodic_minimum_image_distance_core");
        else
            $display("FAIL periodic_minimum_image_distance_core");
        $finish;
    end
endmodule

[files.f]
hw/rtl/pmid_pkg.sv
hw/rtl/pmid_div_cell.sv
hw/rtl/pmid_sqrt_cell.sv
hw/rtl/periodic_minimum_image_distance_core.sv
hw/rtl/pmid_checker.sv
tb/tb_top.sv
